/* src/vce_pkg.sv */
// vce_pkg: shared types, constants and character functions of the visible char escaper
// used by vce_front, vce_fifo, vce_back and visible_char_escaper_core
// no dependencies
package vce_pkg;

  // ascii characters used in the escaped forms
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] CaretFlip = 8'h40;
  localparam logic [7:0] HexUpperOfs = 8'h37;
  localparam logic [7:0] HexLowerOfs = 8'h57;

  // input codes with special handling
  localparam logic [7:0] CodeNl    = 8'h0A;
  localparam logic [7:0] CodeCr    = 8'h0D;
  localparam logic [7:0] CodeEsc   = 8'h1B;
  localparam logic [7:0] CodeSpace = 8'h20;
  localparam logic [7:0] CodeTilde = 8'h7E;

  // register indexes on the configuration port
  localparam logic RegSpaceVisible = 1'b0;
  localparam logic RegNumberBase   = 1'b1;

  // queue between front and back
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    BaseUpper = 2'd0,
    BaseOctal = 2'd1,
    BaseLower = 2'd2,
    BaseBad   = 2'd3
  } base_e;

  // classification of one input byte
  typedef enum logic [3:0] {
    KindErr,
    KindNl,
    KindCr,
    KindEsc,
    KindSpVis,
    KindLit,
    KindCaret,
    KindOct,
    KindHexU,
    KindHexL
  } kind_e;

  typedef struct packed {
    logic  space_visible;
    base_e number_base;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
  } desc_t;

  // index of the final character for a kind
  function automatic logic [2:0] last_idx(kind_e kind);
    logic [2:0] r;
    r = 3'd0;
    unique case (kind)
      KindErr, KindLit:           r = 3'd0;
      KindCaret:                  r = 3'd1;
      KindSpVis:                  r = 3'd2;
      KindNl, KindCr, KindHexU,
      KindHexL:                   r = 3'd3;
      KindEsc, KindOct:           r = 3'd4;
      default:                    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n, logic lower);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = ChZero + {4'h0, n};
    end else if (lower) begin
      r = HexLowerOfs + {4'h0, n};
    end else begin
      r = HexUpperOfs + {4'h0, n};
    end
    return r;
  endfunction

  // character at position idx of the escaped form
  function automatic logic [7:0] char_at(desc_t d, logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx == 3'd0 && d.kind != KindErr && d.kind != KindLit && d.kind != KindCaret) begin
      r = ChLt;
    end else if (idx == last_idx(d.kind) && idx != 3'd0 && d.kind != KindCaret) begin
      r = ChGt;
    end else begin
      case (d.kind)
        KindLit:   r = d.code;
        KindCaret: r = (idx == 3'd0) ? ChCaret : (d.code ^ CaretFlip);
        KindNl:    r = (idx == 3'd1) ? ChN : ChL;
        KindCr:    r = (idx == 3'd1) ? ChC : ChR;
        KindEsc:   r = (idx == 3'd1) ? ChE : ((idx == 3'd2) ? ChS : ChC);
        KindSpVis: r = ChS;
        KindOct: begin
          case (idx)
            3'd1:    r = ChZero + {6'h0, d.code[7:6]};
            3'd2:    r = ChZero + {5'h0, d.code[5:3]};
            default: r = ChZero + {5'h0, d.code[2:0]};
          endcase
        end
        KindHexU:  r = hex_digit((idx == 3'd1) ? d.code[7:4] : d.code[3:0], 1'b0);
        KindHexL:  r = hex_digit((idx == 3'd1) ? d.code[7:4] : d.code[3:0], 1'b1);
        default:   r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

/* src/vce_front.sv */
// vce_front: classifies an incoming byte into an escape descriptor
// depends on vce_pkg
module vce_front (
  input  vce_pkg::cfg_t  cfg_i,
  input  logic [7:0]     byte_i,
  output vce_pkg::desc_t desc_o
);

  // pick the escaped form from the byte and the configuration
  always_comb begin
    desc_o.code = byte_i;
    if (cfg_i.number_base == vce_pkg::BaseBad) begin
      desc_o.kind = vce_pkg::KindErr;
    end else if (byte_i == vce_pkg::CodeNl) begin
      desc_o.kind = vce_pkg::KindNl;
    end else if (byte_i == vce_pkg::CodeCr) begin
      desc_o.kind = vce_pkg::KindCr;
    end else if (byte_i == vce_pkg::CodeEsc) begin
      desc_o.kind = vce_pkg::KindEsc;
    end else if (byte_i == vce_pkg::CodeSpace) begin
      desc_o.kind = cfg_i.space_visible ? vce_pkg::KindSpVis : vce_pkg::KindLit;
    end else if (byte_i > vce_pkg::CodeSpace && byte_i <= vce_pkg::CodeTilde) begin
      desc_o.kind = vce_pkg::KindLit;
    end else if (!byte_i[7]) begin
      desc_o.kind = vce_pkg::KindCaret;
    end else if (cfg_i.number_base == vce_pkg::BaseOctal) begin
      desc_o.kind = vce_pkg::KindOct;
    end else if (cfg_i.number_base == vce_pkg::BaseLower) begin
      desc_o.kind = vce_pkg::KindHexL;
    end else begin
      desc_o.kind = vce_pkg::KindHexU;
    end
  end

endmodule

/* src/vce_fifo.sv */
// vce_fifo: short descriptor queue between front and back
// depends on vce_pkg
module vce_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  vce_pkg::desc_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           rd_valid_o,
  output vce_pkg::desc_t rd_data_o
);

  vce_pkg::desc_t                    mem_q [vce_pkg::FifoDepth];
  logic [vce_pkg::FifoPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [vce_pkg::FifoCntW-1:0]      cnt_q, cnt_d;
  logic                              do_wr, do_rd;

  assign full_o     = (cnt_q == vce_pkg::FifoCntW'(vce_pkg::FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == vce_pkg::FifoPtrW'(vce_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == vce_pkg::FifoPtrW'(vce_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* src/vce_back.sv */
// vce_back: walks each descriptor one character per cycle into the output register while it is free or popped
// depends on vce_pkg
module vce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_valid_i,
  input  vce_pkg::desc_t rd_data_i,
  output logic           rd_en_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     char_o,
  output logic           last_o,
  output logic           err_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic       advance, at_last;

  // output register frees up when empty or its transfer completes
  assign advance = rd_valid_i && (!out_valid_q || pop_i);
  assign at_last = (idx_q == vce_pkg::last_idx(rd_data_i.kind));
  assign rd_en_o = advance && at_last;

  // next character of the current descriptor
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;
    if (advance) begin
      out_valid_d = 1'b1;
      char_d      = vce_pkg::char_at(rd_data_i, idx_q);
      last_d      = at_last;
      err_d       = (rd_data_i.kind == vce_pkg::KindErr);
      idx_d       = at_last ? 3'd0 : idx_q + 3'd1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign empty_o = !out_valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;
  assign err_o   = err_q;

endmodule

/* src/visible_char_escaper_core.sv */
// A pushed byte is stored in the descriptor queue; its first character is then registered when the output is free.
// Throughput: one character per cycle while the output register is free or popped; a byte yields 1 to 5
// characters (its escaped length), from the single output register that the back end fills.
// A two-entry descriptor queue lets the front accept bytes while the back end is busy.
// Reset (rst_ni low, asynchronous) empties the queue and output and clears
// space_visible and number_base to 0.
module visible_char_escaper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_out_o,
  output logic        last_char_o,
  output logic        error_flag_o
);

  vce_pkg::cfg_t  cfg_q, cfg_d;
  vce_pkg::desc_t front_desc, head_desc;
  logic           head_valid, head_pop;
  logic           cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        vce_pkg::RegSpaceVisible: cfg_d.space_visible = pwdata[0];
        vce_pkg::RegNumberBase:   cfg_d.number_base   = vce_pkg::base_e'(pwdata[1:0]);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{space_visible: 1'b0, number_base: vce_pkg::BaseUpper};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register readback
  always_comb begin
    prdata = 32'h0;
    unique case (paddr[2])
      vce_pkg::RegSpaceVisible: prdata = {31'h0, cfg_q.space_visible};
      vce_pkg::RegNumberBase:   prdata = {30'h0, cfg_q.number_base};
      default:                  prdata = 32'h0;
    endcase
  end

  vce_front u_front (
    .cfg_i  (cfg_q),
    .byte_i (byte_in_i),
    .desc_o (front_desc)
  );

  vce_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (front_desc),
    .full_o     (full),
    .rd_en_i    (head_pop),
    .rd_valid_o (head_valid),
    .rd_data_o  (head_desc)
  );

  vce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (head_valid),
    .rd_data_i  (head_desc),
    .rd_en_o    (head_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .char_o     (char_out_o),
    .last_o     (last_char_o),
    .err_o      (error_flag_o)
  );

endmodule

/* src/vce_checker.sv */
// vce_checker: port-level assertions for visible_char_escaper_core
// bound to the top level; no package dependencies
module vce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] char_out_o,
  input logic       last_char_o,
  input logic       error_flag_o
);

  // an error result is the only one for its byte
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && error_flag_o |-> last_char_o)
    else $error("error result not marked last");

  // an error result carries a zero character
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && error_flag_o |-> char_out_o == 8'h00)
    else $error("error result has nonzero character");

  // a normal result is never a zero character
  a_char_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !error_flag_o |-> char_out_o != 8'h00)
    else $error("normal result has zero character");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(char_out_o) && $stable(last_char_o)
      && $stable(error_flag_o))
    else $error("waiting result changed before transfer");

endmodule

bind visible_char_escaper_core vce_checker u_vce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .char_out_o   (char_out_o),
  .last_char_o  (last_char_o),
  .error_flag_o (error_flag_o)
);
